FILE: hw/rtl/sensor_frame_deframer_assert.svh
// Assertion macros for the sensor frame deframer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SENSOR_FRAME_DEFRAMER_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SFD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfd assertion failed");

// Next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfd assertion failed");

`endif

FILE: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the sensor frame deframer.
// No dependencies; used by the top level, the checker and the testbench.
package sfd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAL_FLOOR  = 2'd3;

  localparam logic [7:0]  HEADER_RST      = 8'hEF;
  localparam logic [7:0]  REPORT_ID_RST   = 8'h51;
  localparam logic [15:0] RANGE_LIMIT_RST = 16'd8000;
  localparam logic [7:0]  QUAL_FLOOR_RST  = 8'd15;

  // range report layout (payload byte positions)
  localparam int REPORT_LEN = 20;
  localparam int DIST_POS   = 4;
  localparam int FX_POS     = 12;
  localparam int FY_POS     = 14;
  localparam int QUAL_POS   = 16;
  // payload reads trail the write pointer by this many bytes
  localparam int READ_LAG   = 2;

  function automatic logic rep_byte_wanted(input logic [CNT_W-1:0] pos);
    return ((pos >= CNT_W'(DIST_POS)) && (pos < CNT_W'(DIST_POS + 4))) ||
           ((pos >= CNT_W'(FX_POS)) && (pos <= CNT_W'(QUAL_POS)));
  endfunction

endpackage

FILE: hw/rtl/sfd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sensor frame deframer.
// Does not depend on sfd_pkg.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         device_id;
  logic [7:0]         system_id;
  logic [7:0]         message_id;
  logic [7:0]         sequence_res;
  logic [6:0]         payload_length;
  logic               is_range_report;
  logic [31:0]        distance_mm;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  logic [7:0]         flow_qual;
  logic               distance_valid;
  logic               flow_usable;

  modport source (output valid, output device_id, output system_id, output message_id,
                  output sequence_res, output payload_length, output is_range_report,
                  output distance_mm, output flow_x, output flow_y, output flow_qual,
                  output distance_valid, output flow_usable, input ready);
  modport sink   (input valid, input device_id, input system_id, input message_id,
                  input sequence_res, input payload_length, input is_range_report,
                  input distance_mm, input flow_x, input flow_y, input flow_qual,
                  input distance_valid, input flow_usable, output ready);
endinterface

FILE: hw/rtl/sensor_frame_deframer.sv
`timescale 1ns / 1ps
// Sensor frame deframer: one byte per cycle; input stalls only while a result waits.
// A result is presented the cycle after a matching checksum byte is accepted.
// The payload RAM takes one write and one read per cycle; report bytes are read back
// two bytes behind the write pointer and captured before the checksum byte arrives.
// Synchronous reset clears the parser, output valid and config to defaults;
// the payload RAM is not cleared.
module sensor_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  sfd_in_if.sink                        in_ch,
  sfd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfd_pkg::*;
  `include "sensor_frame_deframer_assert.svh"

  localparam logic [2:0] PH_HEAD    = 3'd0;
  localparam logic [2:0] PH_DEV     = 3'd1;
  localparam logic [2:0] PH_SYS     = 3'd2;
  localparam logic [2:0] PH_MSG     = 3'd3;
  localparam logic [2:0] PH_SEQ     = 3'd4;
  localparam logic [2:0] PH_LEN     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CHECK   = 3'd7;

  // configuration
  logic [7:0]  header_value;
  logic [7:0]  report_id;
  logic [15:0] range_limit;
  logic [7:0]  quality_floor;

  // parser state
  logic [2:0]       phase;
  logic [7:0]       running_sum;
  logic [CNT_W-1:0] payload_count;
  logic [7:0]       hdr_dev, hdr_sys, hdr_msg, hdr_seq, hdr_len;

  // report bytes gathered from the payload RAM
  logic [31:0]       rep_dist;
  logic [15:0]       rep_fx, rep_fy;
  logic [7:0]        rep_q;
  logic              rd_pend;
  logic [ADDR_W-1:0] rd_slot;

  logic              in_acc;
  logic [7:0]        b;
  logic [7:0]        sum_add;
  logic [CNT_W-1:0]  cnt_inc;
  logic              wr_en, rd_en;
  logic [CNT_W-1:0]  rd_pos;
  logic [7:0]        ram_rdata;
  logic              emit;
  logic              rep, dist_nz, dv, fu;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign sum_add     = running_sum + b;
  assign cnt_inc     = payload_count + CNT_W'(1);

  assign wr_en  = in_acc && (phase == PH_PAYLOAD);
  assign rd_pos = payload_count - CNT_W'(READ_LAG);
  assign rd_en  = wr_en && (payload_count >= CNT_W'(READ_LAG)) && rep_byte_wanted(rd_pos);

  sfd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_payload_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (payload_count[ADDR_W-1:0]),
    .wdata (b),
    .re    (rd_en),
    .raddr (rd_pos[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign emit    = in_acc && (phase == PH_CHECK) && (b == running_sum);
  assign rep     = (hdr_msg == report_id) && (hdr_len == 8'(REPORT_LEN));
  assign dist_nz = (rep_dist != 32'd0);
  assign dv      = rep && dist_nz && (rep_dist < {16'd0, range_limit});
  assign fu      = rep && dist_nz && (rep_q > quality_floor);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= HEADER_RST;
      report_id     <= REPORT_ID_RST;
      range_limit   <= RANGE_LIMIT_RST;
      quality_floor <= QUAL_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER:      header_value  <= cfg_data[7:0];
        CFG_REPORT_ID:   report_id     <= cfg_data[7:0];
        CFG_RANGE_LIMIT: range_limit   <= cfg_data[15:0];
        CFG_QUAL_FLOOR:  quality_floor <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      running_sum   <= 8'd0;
      payload_count <= '0;
    end else if (in_acc) begin
      case (phase)
        PH_HEAD: begin
          if (b == header_value) begin
            running_sum <= b;
            phase       <= PH_DEV;
          end
        end
        PH_DEV, PH_SYS, PH_MSG, PH_SEQ: begin
          running_sum <= sum_add;
          phase       <= phase + 3'd1;
        end
        PH_LEN: begin
          running_sum <= sum_add;
          if (b > 8'(MAX_PAYLOAD)) begin
            phase <= PH_HEAD;
          end else if (b == 8'd0) begin
            phase <= PH_CHECK;
          end else begin
            payload_count <= '0;
            phase         <= PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_sum   <= sum_add;
          payload_count <= cnt_inc;
          if (8'(cnt_inc) >= hdr_len) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: phase <= PH_HEAD;
        default:  phase <= PH_HEAD;
      endcase
    end
  end

  // header byte capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (phase)
        PH_DEV:  hdr_dev <= b;
        PH_SYS:  hdr_sys <= b;
        PH_MSG:  hdr_msg <= b;
        PH_SEQ:  hdr_seq <= b;
        PH_LEN:  hdr_len <= b;
        default: ;
      endcase
    end
  end

  // read-back capture of report bytes, in the cycle after each read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
    if (rd_en) begin
      rd_slot <= rd_pos[ADDR_W-1:0];
    end
    if (rd_pend) begin
      case (rd_slot)
        ADDR_W'(DIST_POS):     rep_dist[7:0]   <= ram_rdata;
        ADDR_W'(DIST_POS + 1): rep_dist[15:8]  <= ram_rdata;
        ADDR_W'(DIST_POS + 2): rep_dist[23:16] <= ram_rdata;
        ADDR_W'(DIST_POS + 3): rep_dist[31:24] <= ram_rdata;
        ADDR_W'(FX_POS):       rep_fx[7:0]     <= ram_rdata;
        ADDR_W'(FX_POS + 1):   rep_fx[15:8]    <= ram_rdata;
        ADDR_W'(FY_POS):       rep_fy[7:0]     <= ram_rdata;
        ADDR_W'(FY_POS + 1):   rep_fy[15:8]    <= ram_rdata;
        ADDR_W'(QUAL_POS):     rep_q           <= ram_rdata;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (emit) begin
      out_ch.device_id       <= hdr_dev;
      out_ch.system_id       <= hdr_sys;
      out_ch.message_id      <= hdr_msg;
      out_ch.sequence_res    <= hdr_seq;
      out_ch.payload_length  <= hdr_len[6:0];
      out_ch.is_range_report <= rep;
      out_ch.distance_mm     <= rep ? rep_dist : 32'd0;
      out_ch.flow_x          <= rep ? $signed(rep_fx) : 16'sd0;
      out_ch.flow_y          <= rep ? $signed(rep_fy) : 16'sd0;
      out_ch.flow_qual       <= rep ? rep_q : 8'd0;
      out_ch.distance_valid  <= dv;
      out_ch.flow_usable     <= fu;
    end
  end

  `SFD_ASSERT_IMPLIES(a_payload_in_bounds, (phase == PH_PAYLOAD),
                      ({1'b0, payload_count} < hdr_len) && (hdr_len <= 8'(MAX_PAYLOAD)))
  `SFD_ASSERT_IMPLIES(a_read_in_frame, rd_pend, (phase == PH_PAYLOAD) || (phase == PH_CHECK))
  `SFD_ASSERT_IMPLIES(a_result_source, $rose(out_ch.valid),
                      $past(in_acc) && ($past(phase) == PH_CHECK))
  `SFD_ASSERT_IMPLIES(a_plain_frame_zero, out_ch.valid && !out_ch.is_range_report,
                      (out_ch.distance_mm == 32'd0) && !out_ch.flow_usable)

endmodule

FILE: hw/rtl/sfd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sfd_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sensor frame deframer: watches the byte and result channels and the
// config port, predicts each frame result and compares it. Depends on sfd_pkg and sfd_if.
module sfd_frame_checker
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sfd_in_if                     in_mon,
  sfd_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output logic                  frame_open
);

  typedef enum logic [2:0] {
    ST_HUNT, ST_DEV, ST_SYS, ST_MSG, ST_SEQ, ST_LEN, ST_PAYLOAD, ST_SUM
  } rx_state_e;

  typedef struct packed {
    logic [7:0]         device_id;
    logic [7:0]         system_id;
    logic [7:0]         message_id;
    logic [7:0]         sequence_res;
    logic [6:0]         payload_length;
    logic               is_range_report;
    logic [31:0]        distance_mm;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [7:0]         flow_qual;
    logic               distance_valid;
    logic               flow_usable;
  } frame_result_t;

  // config shadow
  logic [7:0]  header_byte;
  logic [7:0]  report_id;
  logic [15:0] range_limit;
  logic [7:0]  qual_floor;

  // parser shadow
  rx_state_e   rx_state;
  logic [7:0]  frame_sum;
  logic [6:0]  pay_cnt;
  logic [7:0]  hdr_bytes [0:4];
  logic [7:0]  pay_mem [0:MAX_PAYLOAD-1];

  frame_result_t frame_q [$];
  frame_result_t oldest;

  function automatic frame_result_t decode_frame();
    frame_result_t r;
    r = '0;
    r.device_id      = hdr_bytes[0];
    r.system_id      = hdr_bytes[1];
    r.message_id     = hdr_bytes[2];
    r.sequence_res   = hdr_bytes[3];
    r.payload_length = hdr_bytes[4][6:0];
    if (hdr_bytes[2] == report_id && hdr_bytes[4] == REPORT_LEN) begin
      r.is_range_report = 1'b1;
      r.distance_mm     = {pay_mem[DIST_POS+3], pay_mem[DIST_POS+2],
                           pay_mem[DIST_POS+1], pay_mem[DIST_POS]};
      r.flow_x          = {pay_mem[FX_POS+1], pay_mem[FX_POS]};
      r.flow_y          = {pay_mem[FY_POS+1], pay_mem[FY_POS]};
      r.flow_qual       = pay_mem[QUAL_POS];
      r.distance_valid  = (r.distance_mm != 0) && (r.distance_mm < {16'd0, range_limit});
      r.flow_usable     = (r.flow_qual > qual_floor) && (r.distance_mm != 0);
    end
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    case (rx_state)
      ST_HUNT: begin
        if (b == header_byte) begin
          frame_sum = b;
          rx_state  = ST_DEV;
        end
      end
      ST_DEV, ST_SYS, ST_MSG, ST_SEQ: begin
        hdr_bytes[3'(rx_state - ST_DEV)] = b;
        frame_sum = frame_sum + b;
        rx_state  = rx_state_e'(rx_state + 1);
      end
      ST_LEN: begin
        hdr_bytes[4] = b;
        frame_sum = frame_sum + b;
        if (b > MAX_PAYLOAD) begin
          rx_state = ST_HUNT;
        end else if (b == 0) begin
          rx_state = ST_SUM;
        end else begin
          pay_cnt  = '0;
          rx_state = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (pay_cnt < MAX_PAYLOAD) pay_mem[pay_cnt[ADDR_W-1:0]] = b;
        pay_cnt   = pay_cnt + 7'd1;
        frame_sum = frame_sum + b;
        if (pay_cnt >= hdr_bytes[4]) rx_state = ST_SUM;
      end
      default: begin
        // the checksum byte is never re-examined as a header
        rx_state = ST_HUNT;
        if (frame_sum == b) frame_q.push_back(decode_frame());
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      header_byte = HEADER_RST;
      report_id   = REPORT_ID_RST;
      range_limit = RANGE_LIMIT_RST;
      qual_floor  = QUAL_FLOOR_RST;
      rx_state    = ST_HUNT;
      frame_sum   = '0;
      pay_cnt     = '0;
      for (int i = 0; i < 5; i++) hdr_bytes[i] = '0;
      frame_q.delete();
      errors      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER:      header_byte = cfg_data[7:0];
          CFG_REPORT_ID:   report_id   = cfg_data[7:0];
          CFG_RANGE_LIMIT: range_limit = cfg_data;
          CFG_QUAL_FLOOR:  qual_floor  = cfg_data[7:0];
          default: ;
        endcase
      end
      // results first, so a frame closing on this edge is not matched against itself
      if (out_mon.valid && out_mon.ready) begin
        if (frame_q.size() == 0) begin
          errors++;
          $display("%0t: result with no frame pending: expected none, actual dev %0h msg %0h",
                   $time, out_mon.device_id, out_mon.message_id);
        end else begin
          oldest = frame_q.pop_front();
          check_field("device_id", 32'(oldest.device_id), 32'(out_mon.device_id));
          check_field("system_id", 32'(oldest.system_id), 32'(out_mon.system_id));
          check_field("message_id", 32'(oldest.message_id), 32'(out_mon.message_id));
          check_field("sequence_res", 32'(oldest.sequence_res), 32'(out_mon.sequence_res));
          check_field("payload_length", 32'(oldest.payload_length),
                      32'(out_mon.payload_length));
          check_field("is_range_report", 32'(oldest.is_range_report),
                      32'(out_mon.is_range_report));
          check_field("distance_mm", oldest.distance_mm, out_mon.distance_mm);
          check_field("flow_x", 32'(oldest.flow_x), 32'(out_mon.flow_x));
          check_field("flow_y", 32'(oldest.flow_y), 32'(out_mon.flow_y));
          check_field("flow_qual", 32'(oldest.flow_qual), 32'(out_mon.flow_qual));
          check_field("distance_valid", 32'(oldest.distance_valid),
                      32'(out_mon.distance_valid));
          check_field("flow_usable", 32'(oldest.flow_usable), 32'(out_mon.flow_usable));
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.rx_byte);
    end
    pending    = frame_q.size();
    frame_open = (rx_state != ST_HUNT);
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stimulus, config phases, output stalls.
// Depends on sfd_pkg, sfd_if, sensor_frame_deframer and sfd_frame_checker.
module testbench;
  import sfd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 220;
  localparam int NUM_PHASES   = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   check_errors;
  int   frames_pending;
  logic frame_open;

  bit   hold_req = 1'b0;
  int   frame_items = 0;

  // current settings, used only to shape stimulus
  logic [7:0]  cur_header;
  logic [7:0]  cur_report_id;
  logic [15:0] cur_limit;
  logic [7:0]  cur_floor;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  sensor_frame_deframer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfd_frame_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (check_errors),
    .pending    (frames_pending),
    .frame_open (frame_open)
  );

  always #4 clk = ~clk;

  // half with no gap, most others short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_distance();
    logic [31:0] lim;
    lim = {16'd0, cur_limit};
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return lim - 1;
      3: return lim;
      4: return lim + 1;
      5: return 32'hFFFF_FFFF;
      6: return $urandom;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  function automatic logic [7:0] pick_quality();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return cur_floor;
      2: return cur_floor + 8'd1;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the byte transaction completes
  task automatic send_byte(input logic [7:0] b, input bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // len above MAX_PAYLOAD stops after the length byte; sum_err is added to the checksum
  task automatic send_frame(input logic [7:0] dev, input logic [7:0] sys,
                            input logic [7:0] msg, input logic [7:0] seq, input int len,
                            input logic [7:0] sum_err, input bit gaps);
    logic [7:0] body [$];
    logic [7:0] pay [MAX_PAYLOAD];
    logic [7:0] sum;
    logic [31:0] range_mm;
    body = '{cur_header, dev, sys, msg, seq, 8'(len)};
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) pay[i] = 8'($urandom);
      if (len == REPORT_LEN) begin
        range_mm = pick_distance();
        {pay[DIST_POS+3], pay[DIST_POS+2], pay[DIST_POS+1], pay[DIST_POS]} = range_mm;
        pay[QUAL_POS] = pick_quality();
      end
      for (int i = 0; i < len; i++) body.push_back(pay[i]);
      sum = '0;
      foreach (body[i]) sum = sum + body[i];
      body.push_back(sum + sum_err);
    end
    foreach (body[i]) send_byte(body[i], gaps);
    frame_items += body.size();
  endtask

  task automatic random_traffic(input int target);
    int start;
    int r;
    int len;
    logic [7:0] msg;
    bit gaps;
    start = frame_items;
    while (frame_items - start < target) begin
      r    = $urandom_range(0, 99);
      gaps = ($urandom_range(0, 3) != 0);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), gaps);
      end else if (r < 13) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(MAX_PAYLOAD + 1, 255), 8'd0, gaps);
      end else begin
        msg = $urandom_range(0, 1) ? cur_report_id : 8'($urandom);
        r   = $urandom_range(0, 7);
        len = (r < 4) ? REPORT_LEN : (r == 4) ? 0 : (r == 5) ? MAX_PAYLOAD :
              $urandom_range(1, MAX_PAYLOAD - 1);
        send_frame(8'($urandom), 8'($urandom), msg, 8'($urandom), len,
                   ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0, gaps);
      end
    end
  endtask

  // feed non-header filler until the parser is back to hunting
  task automatic close_frame();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (frame_open) begin
      @(posedge clk);
      send_byte(~cur_header, 1'b0);
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] hv, input logic [7:0] rid,
                              input logic [15:0] lim, input logic [7:0] qf);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= {8'($urandom), hv};
    @(posedge clk);
    cfg_index <= CFG_REPORT_ID;
    cfg_data  <= {8'($urandom), rid};
    @(posedge clk);
    cfg_index <= CFG_RANGE_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_index <= CFG_QUAL_FLOOR;
    cfg_data  <= {8'($urandom), qf};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_header    = hv;
    cur_report_id = rid;
    cur_limit     = lim;
    cur_floor     = qf;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int run;
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HEADER;
    cfg_data      = '0;
    cur_header    = HEADER_RST;
    cur_report_id = REPORT_ID_RST;
    cur_limit     = RANGE_LIMIT_RST;
    cur_floor     = QUAL_FLOOR_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: noise while hunting, zero length, oversize, bad sum that looks like a header, one-byte payload
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 8'd0, 1'b0);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, MAX_PAYLOAD + 1, 8'd0, 1'b0);
    send_frame(8'h01, 8'h00, 8'h00, 8'h00, 0, 8'hFF, 1'b0);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1, 8'd0, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        close_frame();
        wait_drained();
        case (ph)
          1: write_config(8'h00, 8'h00, 16'hFFFF, 8'h00);
          2: write_config(8'hFF, 8'hFF, 16'h0000, 8'hFF);
          4: write_config(8'hAA, REPORT_ID_RST, 16'd1, 8'd254);
          default: write_config(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        endcase
      end
      if (ph == 1) hold_req = 1'b1;
      random_traffic(PHASE_ITEMS);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (check_errors == 0 && frames_pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_if.sv
hw/rtl/sfd_ram.sv
hw/rtl/sensor_frame_deframer.sv
tb/sfd_frame_checker.sv
tb/testbench.sv
